// ----- rtl/bmcf_pkg.sv -----
// Package for the bulk message chunk framer: sizes, codes and the command word
// passed from the front end through the queue to the packet engine.
// No dependencies.
`timescale 1ns / 1ps

package bmcf_pkg;

  // Payload bytes per chunk and longest message accepted
  localparam int unsigned CHUNK_BYTES       = 18;
  localparam int unsigned MAX_MESSAGE_BYTES = 4590;

  // Index byte that marks a header packet
  localparam logic [7:0] HEADER_INDEX = 8'd255;

  // Field widths
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADDR_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int unsigned CNT_W  = $clog2(CHUNK_BYTES + 2);

  // Chunk count = ceil(len / CHUNK_BYTES), done as a multiply by an exact
  // reciprocal on x = len + CHUNK_BYTES - 1.
  localparam int unsigned X_W       = LEN_W + 1;
  localparam int unsigned DIV_SHIFT = X_W + $clog2(CHUNK_BYTES);
  localparam int unsigned RECIP_W   = X_W + 1;
  localparam int unsigned PROD_W    = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES));

  // Command queue depth
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  // Status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_ORDER    = 2'd2;

  // Input word kinds
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_DATA,
    CMD_ERR_LONG,
    CMD_ERR_ORDER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [BYTE_W-1:0]  endpoint;  // endpoint of the packet
    logic [BYTE_W-1:0]  aux;       // header: chunk count; data: payload byte
    logic [BYTE_W-1:0]  idx;       // chunk index
    logic [ADDR_W-1:0]  wr_addr;   // buffer slot of the payload byte
    logic               flush;     // chunk complete, send it
  } cmd_t;

endpackage

// ----- rtl/bmcf_front.sv -----
// Front end of the framer: takes input words, tracks message state and issues
// commands to the queue. Depends on bmcf_pkg.
`timescale 1ns / 1ps

module bmcf_front
  import bmcf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic [BYTE_W-1:0] endpoint,
  input  logic [LEN_W-1:0]  message_length,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic              open_r,  open_nxt;
  logic [BYTE_W-1:0] ep_r,    ep_nxt;
  logic [LEN_W-1:0]  rem_r,   rem_nxt;
  logic [BYTE_W-1:0] chunk_r, chunk_nxt;
  logic [ADDR_W-1:0] fill_r,  fill_nxt;

  logic [X_W-1:0]    div_x;
  logic [PROD_W-1:0] div_prod;
  logic [BYTE_W-1:0] chunks;
  logic              last_byte;
  logic              chunk_full;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // ceil(len / CHUNK_BYTES) by reciprocal multiply; 8-bit field keeps low bits
  assign div_x    = X_W'(message_length) + X_W'(CHUNK_BYTES - 1);
  assign div_prod = PROD_W'(div_x) * PROD_W'(RECIP);
  assign chunks   = div_prod[DIV_SHIFT +: BYTE_W];

  assign last_byte  = (rem_r == LEN_W'(1));
  assign chunk_full = (fill_r == ADDR_W'(CHUNK_BYTES - 1));

  always_comb begin
    open_nxt  = open_r;
    ep_nxt    = ep_r;
    rem_nxt   = rem_r;
    chunk_nxt = chunk_r;
    fill_nxt  = fill_r;
    q_cmd     = '{kind: CMD_ERR_ORDER, endpoint: ep_r, aux: data_byte, idx: chunk_r,
                  wr_addr: fill_r, flush: 1'b0};
    if (op == OP_START) begin
      if (open_r) begin
        q_cmd.kind = CMD_ERR_ORDER;
      end else if (message_length > LEN_W'(MAX_MESSAGE_BYTES)) begin
        q_cmd.kind = CMD_ERR_LONG;
      end else begin
        q_cmd.kind     = CMD_HEADER;
        q_cmd.endpoint = endpoint;
        q_cmd.aux      = chunks;
        ep_nxt    = endpoint;
        rem_nxt   = message_length;
        chunk_nxt = '0;
        fill_nxt  = '0;
        open_nxt  = (message_length != '0);
      end
    end else if (!open_r) begin
      q_cmd.kind = CMD_ERR_ORDER;
    end else begin
      q_cmd.kind  = CMD_DATA;
      q_cmd.flush = chunk_full || last_byte;
      rem_nxt     = rem_r - LEN_W'(1);
      if (chunk_full || last_byte) begin
        fill_nxt  = '0;
        chunk_nxt = chunk_r + BYTE_W'(1);
        open_nxt  = !last_byte;
      end else begin
        fill_nxt = fill_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      ep_r    <= '0;
      rem_r   <= '0;
      chunk_r <= '0;
      fill_r  <= '0;
    end else if (q_push) begin
      open_r  <= open_nxt;
      ep_r    <= ep_nxt;
      rem_r   <= rem_nxt;
      chunk_r <= chunk_nxt;
      fill_r  <= fill_nxt;
    end
  end

endmodule

// ----- rtl/bmcf_cmd_fifo.sv -----
// Short command queue between the front end and the packet engine.
// Depends on bmcf_pkg.
`timescale 1ns / 1ps

module bmcf_cmd_fifo
  import bmcf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t               slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign full       = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/bmcf_back.sv -----
// Packet engine: executes queued commands, holds the chunk buffer and
// serialises header, chunk and error words. Depends on bmcf_pkg.
`timescale 1ns / 1ps

module bmcf_back
  import bmcf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  cmd_t              head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  output logic [1:0]        out_status
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HDR,
    PH_PKT
  } phase_t;

  phase_t            phase_r, phase_nxt;
  cmd_t              cmd_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;

  logic [BYTE_W-1:0] buf_mem [CHUNK_BYTES];
  logic [BYTE_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic [1:0]        out_status_r;

  logic              can_load;
  logic              load;
  logic [BYTE_W-1:0] ld_byte;
  logic              ld_last;
  logic [1:0]        ld_status;
  logic              take_cmd;
  logic              payload_last;

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  assign can_load     = !out_valid_r || out_ready;
  assign payload_last = (ptr_r == cmd_r.wr_addr);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    pop       = 1'b0;
    take_cmd  = 1'b0;
    mem_we    = 1'b0;
    load      = 1'b0;
    ld_byte   = '0;
    ld_last   = 1'b0;
    ld_status = STATUS_OK;
    rd_addr   = ptr_r;
    case (phase_r)
      PH_IDLE: begin
        if (head_valid) begin
          case (head_cmd.kind)
            CMD_ERR_LONG, CMD_ERR_ORDER: begin
              if (can_load) begin
                pop       = 1'b1;
                load      = 1'b1;
                ld_status = (head_cmd.kind == CMD_ERR_LONG) ? STATUS_TOO_LONG
                                                            : STATUS_ORDER;
              end
            end
            CMD_HEADER: begin
              pop       = 1'b1;
              take_cmd  = 1'b1;
              cnt_nxt   = '0;
              phase_nxt = PH_HDR;
            end
            CMD_DATA: begin
              pop    = 1'b1;
              mem_we = 1'b1;
              if (head_cmd.flush) begin
                take_cmd  = 1'b1;
                cnt_nxt   = '0;
                ptr_nxt   = '0;
                phase_nxt = PH_PKT;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      PH_HDR: begin
        if (can_load) begin
          load    = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          case (cnt_r)
            CNT_W'(0): ld_byte = cmd_r.endpoint;
            CNT_W'(1): ld_byte = HEADER_INDEX;
            CNT_W'(2): ld_byte = cmd_r.aux;
            default: begin
              ld_byte   = '0;
              ld_last   = 1'b1;
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
      PH_PKT: begin
        if (can_load) begin
          load    = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(0)) begin
            ld_byte = cmd_r.endpoint;
          end else if (cnt_r == CNT_W'(1)) begin
            ld_byte = cmd_r.idx;
          end else begin
            ld_byte = rd_data_r;
            if (payload_last) begin
              ld_last   = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              ptr_nxt = ptr_r + ADDR_W'(1);
              rd_addr = ptr_r + ADDR_W'(1);
            end
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Chunk buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[head_cmd.wr_addr] <= head_cmd.aux;
    end
    rd_data_r <= buf_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_cmd) begin
      cmd_r <= head_cmd;
    end
    if (load) begin
      out_byte_r   <= ld_byte;
      out_last_r   <= ld_last;
      out_status_r <= ld_status;
    end
  end

endmodule

// ----- rtl/bulk_message_chunk_framer.sv -----
// Top level of the bulk message chunk framer: front end, command queue and
// packet engine. Depends on bmcf_pkg, bmcf_front, bmcf_cmd_fifo, bmcf_back.
`timescale 1ns / 1ps

// Channel | Dir | Handshake           | Payload
// --------+-----+---------------------+----------------------------------------
// in_     | in  | in_tvalid/in_tready | tuser op; tdata endpoint, length, byte
// out_    | out | out_tvalid/tready   | tdata out_byte; tlast; tuser status
//
// The front end takes one word per cycle while the four-entry command queue
// has room. The packet engine pops each queued command in its idle phase;
// an error word is loaded in the same cycle as its pop. A header then sends
// four output words and a chunk packet its payload plus two. A full chunk
// of 18 bytes thus makes 20 output words, and the engine pops no command
// while it sends a header or a chunk packet.
// Reset (rst_n low, synchronous) closes any message and empties the queue;
// the chunk buffer is not cleared. out_tready low stalls only the engine;
// the front keeps accepting until the queue fills.

module bulk_message_chunk_framer
  import bmcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] endpoint, [20:8] message_length,
                                  // [28:21] data_byte, [31:29] zero
  input  logic        in_tuser,   // [0] op
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // last_of_packet
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head;

  bmcf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .op             (in_tuser),
    .endpoint       (in_tdata[7:0]),
    .message_length (in_tdata[20:8]),
    .data_byte      (in_tdata[28:21]),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  bmcf_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head)
  );

  bmcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast),
    .out_status (out_tuser)
  );

endmodule

// ----- dv/bulk_message_chunk_framer_tb.sv -----
// Testbench for bulk_message_chunk_framer: directed, random and multi-chunk traffic
// checked word by word against an in-bench model of the framing rules.
// Depends on bmcf_pkg and the framer RTL.
`timescale 1ns / 1ps

module bulk_message_chunk_framer_tb;
  import bmcf_pkg::*;

  // Run sizing
  localparam int RANDOM_WORDS   = 190;
  localparam int LONG_MSG_BYTES = 60;     // three full chunks and a partial one
  localparam int DRAIN_CYCLES   = 60;     // engine latency plus queue, with margin
  // About 280 input words, at most ~20 output words each; even with long stalls
  // a correct run stays far below this.
  localparam int CYCLE_LIMIT    = 100000;
  localparam int PRINT_CAP      = 40;     // keep the log short on a broken build

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last;
    logic [1:0] status;
  } framer_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [7:0] endpoint, [20:8] message_length,
                                // [28:21] data_byte, [31:29] zero
  logic        in_tuser = 1'b0; // [0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] out_byte
  logic        out_tlast;
  logic [1:0]  out_tuser;       // [1:0] status

  bulk_message_chunk_framer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state of the framer
  logic        msg_open    = 1'b0;
  logic [7:0]  cur_ep      = '0;
  logic [12:0] bytes_left  = '0;
  logic [7:0]  chunk_idx   = '0;
  logic [7:0]  chunk_buf [CHUNK_BYTES];
  int          chunk_fill  = 0;

  framer_word_t owed_words [$];

  // Idle controls, one per side
  logic in_idle_on   = 1'b1;
  logic out_stall_on = 1'b1;

  int err_count     = 0;
  int words_in      = 0;
  int starts_in     = 0;
  int words_out     = 0;
  int packets_out   = 0;
  int cycle_count   = 0;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("[%0t] mismatch %0d: %s", $realtime, err_count, what);
  endtask

  task automatic owe_word(input logic [7:0] b, input logic last, input logic [1:0] st);
    framer_word_t w;
    w.pkt_byte = b;
    w.last     = last;
    w.status   = st;
    owed_words.push_back(w);
  endtask

  // Model: what one accepted input word makes the framer emit
  task automatic frame_word(input logic op, input logic [7:0] ep, input logic [12:0] len,
                            input logic [7:0] db);
    int unsigned chunks;
    int i;
    if (op == OP_START) begin
      if (msg_open) begin
        // start on top of an open message: flagged, message carries on
        owe_word(8'd0, 1'b0, STATUS_ORDER);
      end else if (len > MAX_MESSAGE_BYTES) begin
        owe_word(8'd0, 1'b0, STATUS_TOO_LONG);
      end else begin
        chunks = (int'(len) + CHUNK_BYTES - 1) / CHUNK_BYTES;
        owe_word(ep, 1'b0, STATUS_OK);
        owe_word(HEADER_INDEX, 1'b0, STATUS_OK);
        owe_word(chunks[7:0], 1'b0, STATUS_OK);
        owe_word(8'd0, 1'b1, STATUS_OK);        // trailing byte, always zero
        cur_ep     = ep;
        bytes_left = len;
        chunk_idx  = '0;
        chunk_fill = 0;
        msg_open   = (len != 0);               // empty message closes at once
      end
    end else if (!msg_open) begin
      owe_word(8'd0, 1'b0, STATUS_ORDER);      // stray byte, dropped
    end else begin
      chunk_buf[chunk_fill] = db;
      chunk_fill++;
      bytes_left--;
      if (chunk_fill == CHUNK_BYTES || bytes_left == 0) begin
        owe_word(cur_ep, 1'b0, STATUS_OK);
        owe_word(chunk_idx, 1'b0, STATUS_OK);
        for (i = 0; i < chunk_fill; i++)
          owe_word(chunk_buf[i], (i == chunk_fill - 1), STATUS_OK);
        chunk_idx++;
        chunk_fill = 0;
        if (bytes_left == 0) msg_open = 1'b0;
      end
    end
  endtask

  // Offer one word, hold it until taken, then update the model.
  // Called at a rising edge; returns at the edge that took the word.
  task automatic send_word(input logic op, input logic [7:0] ep, input logic [12:0] len,
                           input logic [7:0] db);
    if (in_idle_on)
      while ($urandom_range(99) < 33) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, db, len, ep};
    do @(posedge clk); while (!in_tready);
    words_in++;
    if (op == OP_START) starts_in++;
    frame_word(op, ep, len, db);
  endtask

  // Sink side: random back-pressure when enabled
  always @(posedge clk) begin
    out_tready <= !out_stall_on || ($urandom_range(99) >= 33);
  end

  // Result checker: every accepted word against the oldest owed one
  always @(posedge clk) begin : check_results
    framer_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_out++;
      if (out_tlast) packets_out++;
      if (owed_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word byte %02h last %0b status %0d",
                                  out_tdata, out_tlast, out_tuser));
      end else begin
        want = owed_words.pop_front();
        if (out_tdata !== want.pkt_byte)
          report_mismatch($sformatf("byte %02h, wanted %02h", out_tdata, want.pkt_byte));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %0b, wanted %0b (byte %02h)",
                                    out_tlast, want.last, want.pkt_byte));
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", out_tuser, want.status));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count,
               owed_words.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Error paths, empty and short messages, a single full chunk
  task automatic test_directed();
    int i;
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
    send_word(OP_DATA, 8'hFF, 13'h1FFF, 8'hFF);                 // byte with nothing open
    send_word(OP_START, 8'h00, 13'd0, 8'h00);                   // empty message
    send_word(OP_START, 8'h5A, 13'(MAX_MESSAGE_BYTES + 1), 8'h00);
    send_word(OP_START, 8'hFF, 13'h1FFF, 8'hFF);                // longest length field
    send_word(OP_START, 8'hFF, 13'd2, 8'h00);                   // one partial chunk
    send_word(OP_DATA, 8'h00, 13'd0, 8'h00);
    send_word(OP_DATA, 8'hFF, 13'h1FFF, 8'hFF);
    send_word(OP_START, 8'hA5, 13'(CHUNK_BYTES), 8'h3C);        // exactly one chunk
    send_word(OP_START, 8'h03, 13'd5, 8'hC3);                   // start while open
    for (i = 0; i < CHUNK_BYTES; i++)
      send_word(OP_DATA, 8'($urandom), 13'($urandom), 8'($urandom));
  endtask

  // Mostly well-formed messages with random sizes, plus stray and bad words
  task automatic test_random_traffic();
    int sent;
    int r;
    sent = 0;
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
    while (sent < RANDOM_WORDS) begin
      r = $urandom_range(99);
      if (msg_open) begin
        if (r < 5)
          send_word(OP_START, 8'($urandom), 13'($urandom), 8'($urandom));
        else
          send_word(OP_DATA, 8'($urandom), 13'($urandom), 8'($urandom));
      end else if (r < 8) begin
        send_word(OP_DATA, 8'($urandom), 13'($urandom), 8'($urandom));
      end else if (r < 14) begin
        send_word(OP_START, 8'($urandom),
                  13'($urandom_range(MAX_MESSAGE_BYTES + 1, 8191)), 8'($urandom));
      end else begin
        // small messages mostly, some spanning several chunks
        send_word(OP_START, 8'($urandom),
                  13'(($urandom_range(3) == 0) ? $urandom_range(0, 100)
                                               : $urandom_range(1, 40)),
                  8'($urandom));
      end
      sent++;
    end
    // close off whatever is still open
    while (msg_open)
      send_word(OP_DATA, 8'($urandom), 13'($urandom), 8'($urandom));
  endtask

  // Multi-chunk message sent back to back with no idling on either side
  task automatic test_long_message();
    int i;
    in_idle_on   = 1'b0;
    out_stall_on = 1'b0;
    send_word(OP_START, 8'h81, 13'(LONG_MSG_BYTES), 8'($urandom));
    for (i = 0; i < LONG_MSG_BYTES; i++)
      send_word(OP_DATA, 8'($urandom), 13'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic();
    test_long_message();
    in_tvalid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words (%0d starts); checked %0d result words in %0d packets,",
             words_in, starts_in, words_out, packets_out);
    $display("covering error paths, random framing and a %0d-byte message without gaps.",
             LONG_MSG_BYTES);
    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- bulk_message_chunk_framer.f -----
rtl/bmcf_pkg.sv
rtl/bmcf_front.sv
rtl/bmcf_cmd_fifo.sv
rtl/bmcf_back.sv
rtl/bulk_message_chunk_framer.sv
dv/bulk_message_chunk_framer_tb.sv
